/* hw/rtl/prsc_pkg.sv */
// ----------------------------------------------------------------------------
// Pen report signature classifier package
// Shared widths, protocol codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package prsc_pkg;

    localparam int TIME_WIDTH_DEFAULT  = 32;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int REG_WIDTH      = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int IN_DATA_WIDTH  = 136;
    localparam int OUT_DATA_WIDTH = 24;

    // Register reset values.
    localparam logic [REG_WIDTH-1:0] VENDOR_RESET     = 16'd11551;
    localparam logic [REG_WIDTH-1:0] PRODUCT_RESET    = 16'd337;
    localparam logic [REG_WIDTH-1:0] IDLE_RESET_RESET = 16'd1500;
    localparam logic [REG_WIDTH-1:0] EVIDENCE_RESET   = 16'd1000;
    localparam logic [REG_WIDTH-1:0] A_GOAL_RESET     = 16'd20;
    localparam logic [REG_WIDTH-1:0] CONTACT_RESET    = 16'd20;
    localparam logic [REG_WIDTH-1:0] SAT_LEVEL_RESET  = 16'd4000;

    // Report filter codes.
    localparam logic [15:0] USAGE_PAGE_DIGITIZER = 16'h000D;
    localparam logic [15:0] USAGE_PEN            = 16'h0002;
    localparam logic [7:0]  REPORT_ID_PEN        = 8'h02;

    // Pen mode codes.
    localparam logic [7:0] MODE_A_HOVER   = 8'h20;
    localparam logic [7:0] MODE_A_CONTACT = 8'h21;
    localparam logic [7:0] MODE_B_HOVER   = 8'h28;
    localparam logic [7:0] MODE_B_CONTACT = 8'h2C;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_A    = 2'd1,
        SIG_B    = 2'd2
    } sig_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXPECTED_VENDOR  = 3'd0,
        CFG_EXPECTED_PRODUCT = 3'd1,
        CFG_IDLE_RESET_MS    = 3'd2,
        CFG_EVIDENCE_MS      = 3'd3,
        CFG_PATTERN_A_GOAL   = 3'd4,
        CFG_CONTACT_GOAL     = 3'd5,
        CFG_SATURATION_LEVEL = 3'd6
    } cfg_index_t;

endpackage

/* hw/rtl/pen_report_signature_classifier.sv */
// ----------------------------------------------------------------------------
// Pen report signature classifier
// Filters decoded pen reports and tracks pattern A / pattern B evidence.
// ----------------------------------------------------------------------------
// The block takes one report transfer per clock cycle while the result side
// does not stall, and returns one result transfer per report: a report waits
// first in the input register and then in the result register. The rate is
// set by the update of the tracking state, which sits between those two
// registers and finishes each report before the next one reaches it. A stall
// on the result side holds one result and one waiting report before the input
// side stops. Configuration writes are taken in any cycle and should only be
// issued while no report is in flight.
module pen_report_signature_classifier #(
    parameter int TIME_WIDTH  = prsc_pkg::TIME_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = prsc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [prsc_pkg::REG_WIDTH-1:0]      cfg_data,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vendor_id[15:0], product_id[31:16], usage_page[47:32], usage_code[63:48],
    // name_matches[64], parse_ok[65], report_id[73:66], pen_mode[81:74],
    // pressure[97:82], now_ms[129:98], zero fill[135:130]
    input  logic [prsc_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // accepted[0], signature[2:1], pressure_valid[3], latest_pressure[19:4],
    // zero fill[23:20]
    output logic [prsc_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);

    localparam int CMP_WIDTH = ((COUNT_WIDTH > prsc_pkg::REG_WIDTH) ?
                                COUNT_WIDTH : prsc_pkg::REG_WIDTH) + 1;

    typedef logic [TIME_WIDTH-1:0]  time_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    function automatic count_t sat_inc(input count_t c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Configuration registers.
    logic [15:0] expected_vendor_reg, expected_product_reg, idle_reset_ms_reg;
    logic [15:0] evidence_ms_reg, pattern_a_goal_reg, contact_goal_reg;
    logic [15:0] saturation_level_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_vendor_reg  <= prsc_pkg::VENDOR_RESET;
            expected_product_reg <= prsc_pkg::PRODUCT_RESET;
            idle_reset_ms_reg    <= prsc_pkg::IDLE_RESET_RESET;
            evidence_ms_reg      <= prsc_pkg::EVIDENCE_RESET;
            pattern_a_goal_reg   <= prsc_pkg::A_GOAL_RESET;
            contact_goal_reg     <= prsc_pkg::CONTACT_RESET;
            saturation_level_reg <= prsc_pkg::SAT_LEVEL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                prsc_pkg::CFG_EXPECTED_VENDOR:  expected_vendor_reg  <= cfg_data;
                prsc_pkg::CFG_EXPECTED_PRODUCT: expected_product_reg <= cfg_data;
                prsc_pkg::CFG_IDLE_RESET_MS:    idle_reset_ms_reg    <= cfg_data;
                prsc_pkg::CFG_EVIDENCE_MS:      evidence_ms_reg      <= cfg_data;
                prsc_pkg::CFG_PATTERN_A_GOAL:   pattern_a_goal_reg   <= cfg_data;
                prsc_pkg::CFG_CONTACT_GOAL:     contact_goal_reg     <= cfg_data;
                prsc_pkg::CFG_SATURATION_LEVEL: saturation_level_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    logic                               in_valid_reg;
    logic [prsc_pkg::IN_DATA_WIDTH-1:0] in_data_reg;
    logic                               out_valid_reg;
    logic                               advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    // Report fields.
    logic [15:0] vendor_id, product_id, usage_page, usage_code, pressure;
    logic        name_matches, parse_ok;
    logic [7:0]  report_id, pen_mode;
    logic [31:0] now_ms;

    assign vendor_id    = in_data_reg[15:0];
    assign product_id   = in_data_reg[31:16];
    assign usage_page   = in_data_reg[47:32];
    assign usage_code   = in_data_reg[63:48];
    assign name_matches = in_data_reg[64];
    assign parse_ok     = in_data_reg[65];
    assign report_id    = in_data_reg[73:66];
    assign pen_mode     = in_data_reg[81:74];
    assign pressure     = in_data_reg[97:82];
    assign now_ms       = in_data_reg[129:98];

    // Tracking state.
    prsc_pkg::sig_t verdict_reg, verdict_next;
    logic   have_last_reg, have_last_next;
    time_t  last_time_reg, last_time_next;
    logic   have_run_start_reg, have_run_start_next;
    time_t  run_start_time_reg, run_start_time_next;
    logic   seen_pattern_a_reg, seen_pattern_a_next;
    count_t pattern_a_count_reg, pattern_a_count_next;
    count_t contact_count_reg, contact_count_next;
    count_t saturated_count_reg, saturated_count_next;
    logic   held_pressure_valid_reg, held_pressure_valid_next;
    logic [15:0] held_pressure_reg, held_pressure_next;

    logic   report_ok;
    logic   idle_clear;
    time_t  now_t;
    time_t  gap;
    time_t  run_time;
    logic   is_mode_a, is_mode_b;
    logic   run_long;
    logic [COUNT_WIDTH:0] sat_twice;

    assign now_t = TIME_WIDTH'(now_ms);

    assign report_ok = (vendor_id == expected_vendor_reg) &&
                       (product_id == expected_product_reg) &&
                       (usage_page == prsc_pkg::USAGE_PAGE_DIGITIZER) &&
                       (usage_code == prsc_pkg::USAGE_PEN) &&
                       name_matches && parse_ok &&
                       (report_id == prsc_pkg::REPORT_ID_PEN);

    assign gap        = now_t - last_time_reg;
    assign idle_clear = have_last_reg && (gap >= TIME_WIDTH'(idle_reset_ms_reg));
    assign is_mode_a  = (pen_mode == prsc_pkg::MODE_A_HOVER) ||
                        (pen_mode == prsc_pkg::MODE_A_CONTACT);
    assign is_mode_b  = (pen_mode == prsc_pkg::MODE_B_HOVER) ||
                        (pen_mode == prsc_pkg::MODE_B_CONTACT);

    always_comb
    begin
        verdict_next             = verdict_reg;
        have_last_next           = have_last_reg;
        last_time_next           = last_time_reg;
        have_run_start_next      = have_run_start_reg;
        run_start_time_next      = run_start_time_reg;
        seen_pattern_a_next      = seen_pattern_a_reg;
        pattern_a_count_next     = pattern_a_count_reg;
        contact_count_next       = contact_count_reg;
        saturated_count_next     = saturated_count_reg;
        held_pressure_valid_next = held_pressure_valid_reg;
        held_pressure_next       = held_pressure_reg;
        run_time                 = '0;
        run_long                 = 1'b0;
        sat_twice                = '0;

        if (report_ok)
        begin
            // A long silence starts a fresh epoch before this report counts.
            if (idle_clear)
            begin
                verdict_next         = prsc_pkg::SIG_NONE;
                have_run_start_next  = 1'b0;
                run_start_time_next  = '0;
                seen_pattern_a_next  = 1'b0;
                pattern_a_count_next = '0;
                contact_count_next   = '0;
                saturated_count_next = '0;
            end
            have_last_next           = 1'b1;
            last_time_next           = now_t;
            held_pressure_valid_next = 1'b1;
            held_pressure_next       = pressure;

            if (is_mode_a)
            begin
                if (verdict_next == prsc_pkg::SIG_B)
                begin
                    verdict_next = prsc_pkg::SIG_NONE;
                end
                seen_pattern_a_next  = 1'b1;
                pattern_a_count_next = sat_inc(pattern_a_count_next);
                have_run_start_next  = 1'b0;
                run_start_time_next  = '0;
                contact_count_next   = '0;
                saturated_count_next = '0;
                if (CMP_WIDTH'(pattern_a_count_next) >= CMP_WIDTH'(pattern_a_goal_reg))
                begin
                    verdict_next = prsc_pkg::SIG_A;
                end
            end
            else if (is_mode_b)
            begin
                // The first report of a run starts its clock at zero length.
                if (have_run_start_next)
                begin
                    run_time = now_t - run_start_time_next;
                end
                else
                begin
                    have_run_start_next = 1'b1;
                    run_start_time_next = now_t;
                end
                if (pen_mode == prsc_pkg::MODE_B_CONTACT)
                begin
                    contact_count_next = sat_inc(contact_count_next);
                    if (pressure >= saturation_level_reg)
                    begin
                        saturated_count_next = sat_inc(saturated_count_next);
                    end
                end
                run_long  = run_time >= TIME_WIDTH'(evidence_ms_reg);
                sat_twice = {saturated_count_next, 1'b0};
                if (seen_pattern_a_next)
                begin
                    if (run_long)
                    begin
                        verdict_next = prsc_pkg::SIG_NONE;
                    end
                end
                else if (run_long &&
                         (CMP_WIDTH'(contact_count_next) >= CMP_WIDTH'(contact_goal_reg)) &&
                         (sat_twice >= {1'b0, contact_count_next}))
                begin
                    verdict_next = prsc_pkg::SIG_B;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_reg             <= prsc_pkg::SIG_NONE;
            have_last_reg           <= 1'b0;
            last_time_reg           <= '0;
            have_run_start_reg      <= 1'b0;
            run_start_time_reg      <= '0;
            seen_pattern_a_reg      <= 1'b0;
            pattern_a_count_reg     <= '0;
            contact_count_reg       <= '0;
            saturated_count_reg     <= '0;
            held_pressure_valid_reg <= 1'b0;
            held_pressure_reg       <= '0;
        end
        else if (advance)
        begin
            verdict_reg             <= verdict_next;
            have_last_reg           <= have_last_next;
            last_time_reg           <= last_time_next;
            have_run_start_reg      <= have_run_start_next;
            run_start_time_reg      <= run_start_time_next;
            seen_pattern_a_reg      <= seen_pattern_a_next;
            pattern_a_count_reg     <= pattern_a_count_next;
            contact_count_reg       <= contact_count_next;
            saturated_count_reg     <= saturated_count_next;
            held_pressure_valid_reg <= held_pressure_valid_next;
            held_pressure_reg       <= held_pressure_next;
        end
    end

    // Result register.
    logic [prsc_pkg::OUT_DATA_WIDTH-1:0] out_data_reg, out_data_next;

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = report_ok;
        out_data_next[2:1]   = verdict_next;
        out_data_next[3]     = held_pressure_valid_next;
        out_data_next[19:4]  = held_pressure_valid_next ? held_pressure_next : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A taken report always lands in the input register.
    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted report did not reach the input register");

    // Pattern B is never declared once pattern A was seen in this epoch.
    a_b_excludes_a: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_reg == prsc_pkg::SIG_B) |-> !seen_pattern_a_reg)
        else $error("pattern B verdict in a mixed epoch");

    // Contacts are only counted inside an open pattern B run.
    a_contacts_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        !have_run_start_reg |-> (contact_count_reg == '0))
        else $error("contact count outside a pattern B run");

    // Held pressure and last timestamp are set and cleared together.
    a_pressure_last: assert property (@(posedge clk) disable iff (!rst_n)
        held_pressure_valid_reg == have_last_reg)
        else $error("held pressure and last time out of step");

    // An accepted report always leaves a pressure held.
    a_accept_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[0]) |-> out_data_reg[3])
        else $error("accepted result without a held pressure");
`endif

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Pen report signature classifier testbench
// Streams decoded pen reports through the classifier under random source gaps
// and sink stalls. A built-in tracker predicts the verdict, acceptance and held
// pressure of every report, and each result transfer is checked against it.
// The run covers the acceptance filters, both evidence patterns, mixed
// epochs, idle clearing, timestamp wrap, long back-to-back runs and register
// settings from zero to full scale.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 1000000;

    // Fields from the lowest bit up: vendor_id, product_id, usage_page,
    // usage_code, name_matches, parse_ok, report_id, pen_mode, pressure, now_ms.
    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] pressure;
        logic [7:0]  pen_mode;
        logic [7:0]  report_id;
        logic        parse_ok;
        logic        name_matches;
        logic [15:0] usage_code;
        logic [15:0] usage_page;
        logic [15:0] product_id;
        logic [15:0] vendor_id;
    } pen_report_t;

    // Fields from the lowest bit up: accepted, signature, pressure_valid,
    // latest_pressure.
    typedef struct packed {
        logic [15:0]    latest_pressure;
        logic           pressure_valid;
        prsc_pkg::sig_t signature;
        logic           accepted;
    } verdict_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [prsc_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [prsc_pkg::REG_WIDTH-1:0]      cfg_data = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [prsc_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b1;
    logic [prsc_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata;

    // Shadow copy of the register file, indexed by register index.
    logic [15:0] regs [0:6] = '{prsc_pkg::VENDOR_RESET, prsc_pkg::PRODUCT_RESET,
                                prsc_pkg::IDLE_RESET_RESET, prsc_pkg::EVIDENCE_RESET,
                                prsc_pkg::A_GOAL_RESET, prsc_pkg::CONTACT_RESET,
                                prsc_pkg::SAT_LEVEL_RESET};

    // Tracking state of the predicted classifier.
    prsc_pkg::sig_t trk_verdict = prsc_pkg::SIG_NONE;
    logic        trk_have_last = 1'b0;
    logic [31:0] trk_last_ms = '0;
    logic        trk_have_run = 1'b0;
    logic [31:0] trk_run_start_ms = '0;
    logic        trk_seen_a = 1'b0;
    logic [15:0] trk_a_count = '0;
    logic [15:0] trk_contacts = '0;
    logic [15:0] trk_saturated = '0;
    logic        trk_press_valid = 1'b0;
    logic [15:0] trk_press = '0;

    verdict_t    pending_verdicts [$];
    logic [31:0] clock_ms = '0;
    bit          idle_en = 1'b1;
    int          stall_left = 0;
    int          cycles = 0;
    int          mismatches = 0;
    int          n_reports = 0;
    int          n_accepted = 0;
    int          n_sig_a = 0;
    int          n_sig_b = 0;

    pen_report_signature_classifier u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_verdicts.size());
            $display("[pen_report_signature_classifier] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (!idle_en)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] count);
        return (count == 16'hFFFF) ? count : count + 16'd1;
    endfunction

    function automatic pen_report_t good_report(input logic [7:0] mode,
                                                input logic [15:0] press,
                                                input logic [31:0] stamp);
        pen_report_t r;
        r.vendor_id    = regs[prsc_pkg::CFG_EXPECTED_VENDOR];
        r.product_id   = regs[prsc_pkg::CFG_EXPECTED_PRODUCT];
        r.usage_page   = prsc_pkg::USAGE_PAGE_DIGITIZER;
        r.usage_code   = prsc_pkg::USAGE_PEN;
        r.name_matches = 1'b1;
        r.parse_ok     = 1'b1;
        r.report_id    = prsc_pkg::REPORT_ID_PEN;
        r.pen_mode     = mode;
        r.pressure     = press;
        r.now_ms       = stamp;
        return r;
    endfunction

    // Spoils exactly one of the seven acceptance checks.
    function automatic pen_report_t break_filter(input pen_report_t r, input int which);
        case (which)
            0: r.vendor_id = r.vendor_id ^ 16'($urandom_range(1, 65535));
            1: r.product_id = r.product_id ^ 16'($urandom_range(1, 65535));
            2: r.usage_page = r.usage_page ^ 16'($urandom_range(1, 65535));
            3: r.usage_code = r.usage_code ^ 16'($urandom_range(1, 65535));
            4: r.name_matches = 1'b0;
            5: r.parse_ok = 1'b0;
            default: r.report_id = r.report_id ^ 8'($urandom_range(1, 255));
        endcase
        return r;
    endfunction

    // Updates the tracker with one report and queues the result it implies.
    task automatic classify_report(input pen_report_t r);
        logic        ok;
        logic [31:0] run_ms;
        verdict_t    res;
        ok = r.vendor_id == regs[prsc_pkg::CFG_EXPECTED_VENDOR]
          && r.product_id == regs[prsc_pkg::CFG_EXPECTED_PRODUCT]
          && r.usage_page == prsc_pkg::USAGE_PAGE_DIGITIZER
          && r.usage_code == prsc_pkg::USAGE_PEN
          && r.name_matches && r.parse_ok && r.report_id == prsc_pkg::REPORT_ID_PEN;
        if (ok)
        begin
            // The gap wraps modulo 2^32, so an earlier stamp reads as a long gap.
            if (trk_have_last
                && (r.now_ms - trk_last_ms) >= regs[prsc_pkg::CFG_IDLE_RESET_MS])
            begin
                trk_verdict      = prsc_pkg::SIG_NONE;
                trk_have_run     = 1'b0;
                trk_run_start_ms = '0;
                trk_seen_a       = 1'b0;
                trk_a_count      = '0;
                trk_contacts     = '0;
                trk_saturated    = '0;
            end
            trk_have_last   = 1'b1;
            trk_last_ms     = r.now_ms;
            trk_press_valid = 1'b1;
            trk_press       = r.pressure;
            if (r.pen_mode == prsc_pkg::MODE_A_HOVER
                || r.pen_mode == prsc_pkg::MODE_A_CONTACT)
            begin
                if (trk_verdict == prsc_pkg::SIG_B)
                    trk_verdict = prsc_pkg::SIG_NONE;
                trk_seen_a       = 1'b1;
                trk_a_count      = bump(trk_a_count);
                trk_have_run     = 1'b0;
                trk_run_start_ms = '0;
                trk_contacts     = '0;
                trk_saturated    = '0;
                if (trk_a_count >= regs[prsc_pkg::CFG_PATTERN_A_GOAL])
                    trk_verdict = prsc_pkg::SIG_A;
            end
            else if (r.pen_mode == prsc_pkg::MODE_B_HOVER
                     || r.pen_mode == prsc_pkg::MODE_B_CONTACT)
            begin
                if (!trk_have_run)
                begin
                    trk_have_run     = 1'b1;
                    trk_run_start_ms = r.now_ms;
                end
                if (r.pen_mode == prsc_pkg::MODE_B_CONTACT)
                begin
                    trk_contacts = bump(trk_contacts);
                    if (r.pressure >= regs[prsc_pkg::CFG_SATURATION_LEVEL])
                        trk_saturated = bump(trk_saturated);
                end
                run_ms = r.now_ms - trk_run_start_ms;
                if (trk_seen_a)
                begin
                    // A mixed epoch never turns into pattern B.
                    if (run_ms >= regs[prsc_pkg::CFG_EVIDENCE_MS])
                        trk_verdict = prsc_pkg::SIG_NONE;
                end
                else if (run_ms >= regs[prsc_pkg::CFG_EVIDENCE_MS]
                         && trk_contacts >= regs[prsc_pkg::CFG_CONTACT_GOAL]
                         && {trk_saturated, 1'b0} >= {1'b0, trk_contacts})
                begin
                    trk_verdict = prsc_pkg::SIG_B;
                end
            end
            n_accepted++;
        end
        res.accepted        = ok;
        res.signature       = trk_verdict;
        res.pressure_valid  = trk_press_valid;
        res.latest_pressure = trk_press_valid ? trk_press : 16'd0;
        if (res.signature == prsc_pkg::SIG_A)
            n_sig_a++;
        if (res.signature == prsc_pkg::SIG_B)
            n_sig_b++;
        n_reports++;
        pending_verdicts.push_back(res);
    endtask

    task automatic send_report(input pen_report_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(prsc_pkg::IN_DATA_WIDTH - $bits(pen_report_t)){1'b0}}, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        classify_report(r);
    endtask

    task automatic write_reg(input prsc_pkg::cfg_index_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        regs[idx] = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Every report yields a result, so an empty queue means the pipeline is empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] vendor, input logic [15:0] product,
                                  input logic [15:0] idle_ms, input logic [15:0] ev_ms,
                                  input logic [15:0] a_goal, input logic [15:0] c_goal,
                                  input logic [15:0] sat_level);
        drain();
        write_reg(prsc_pkg::CFG_EXPECTED_VENDOR, vendor);
        write_reg(prsc_pkg::CFG_EXPECTED_PRODUCT, product);
        write_reg(prsc_pkg::CFG_IDLE_RESET_MS, idle_ms);
        write_reg(prsc_pkg::CFG_EVIDENCE_MS, ev_ms);
        write_reg(prsc_pkg::CFG_PATTERN_A_GOAL, a_goal);
        write_reg(prsc_pkg::CFG_CONTACT_GOAL, c_goal);
        write_reg(prsc_pkg::CFG_SATURATION_LEVEL, sat_level);
    endtask

    task automatic apply_reset_settings();
        apply_settings(prsc_pkg::VENDOR_RESET, prsc_pkg::PRODUCT_RESET,
                       prsc_pkg::IDLE_RESET_RESET, prsc_pkg::EVIDENCE_RESET,
                       prsc_pkg::A_GOAL_RESET, prsc_pkg::CONTACT_RESET,
                       prsc_pkg::SAT_LEVEL_RESET);
    endtask

    task automatic test_report_filters();
        apply_reset_settings();
        idle_en = 1'b1;
        send_report(good_report(prsc_pkg::MODE_A_CONTACT, 16'd0, 32'd1000));
        for (int w = 0; w < 7; w++)
            send_report(break_filter(good_report(prsc_pkg::MODE_B_CONTACT, 16'hFFFF,
                                                 32'd1001), w));
        send_report(good_report(8'hFF, 16'hFFFF, 32'd1002));
        send_report(good_report(prsc_pkg::MODE_B_HOVER, 16'd100, 32'd1003));
        // An earlier stamp and a wrap to all ones both read as long gaps.
        send_report(good_report(prsc_pkg::MODE_B_CONTACT, 16'd4000, 32'd0));
        send_report(good_report(prsc_pkg::MODE_A_HOVER, 16'd7, 32'hFFFF_FFFF));
        send_report(good_report(prsc_pkg::MODE_A_HOVER, 16'd8, 32'd5));
    endtask

    task automatic test_pattern_verdicts();
        apply_settings(prsc_pkg::VENDOR_RESET, prsc_pkg::PRODUCT_RESET, 16'd100, 16'd20,
                       16'd2, 16'd2, 16'd1000);
        send_report(good_report(prsc_pkg::MODE_B_CONTACT, 16'd1000, 32'd5000));
        send_report(good_report(prsc_pkg::MODE_B_CONTACT, 16'd999, 32'd5010));
        send_report(good_report(prsc_pkg::MODE_B_HOVER, 16'd0, 32'd5020));
        send_report(good_report(prsc_pkg::MODE_A_HOVER, 16'd10, 32'd5030));
        send_report(good_report(prsc_pkg::MODE_A_CONTACT, 16'd11, 32'd5040));
        send_report(good_report(prsc_pkg::MODE_B_CONTACT, 16'd2000, 32'd5050));
        send_report(good_report(prsc_pkg::MODE_B_CONTACT, 16'd2000, 32'd5070));
        send_report(good_report(prsc_pkg::MODE_B_CONTACT, 16'd2000, 32'd5170));
        // With zero goals and zero durations every check is met at once.
        apply_settings(prsc_pkg::VENDOR_RESET, prsc_pkg::PRODUCT_RESET, 16'd0, 16'd0,
                       16'd0, 16'd0, 16'd0);
        send_report(good_report(prsc_pkg::MODE_B_HOVER, 16'd0, 32'd7));
        send_report(good_report(prsc_pkg::MODE_B_CONTACT, 16'd0, 32'd7));
        send_report(good_report(prsc_pkg::MODE_A_HOVER, 16'd3, 32'd8));
    endtask

    // Long back-to-back runs of each pattern with no source gaps or sink stalls.
    task automatic test_back_to_back_runs();
        apply_settings(prsc_pkg::VENDOR_RESET, prsc_pkg::PRODUCT_RESET, 16'hFFFF, 16'd0,
                       16'hFFFF, 16'hFFFF, 16'd0);
        idle_en = 1'b0;
        clock_ms = $urandom();
        for (int i = 0; i < 100; i++)
        begin
            clock_ms += 1;
            send_report(good_report(prsc_pkg::MODE_A_CONTACT, 16'($urandom()), clock_ms));
        end
        clock_ms += 32'h0001_0000;
        for (int i = 0; i < 100; i++)
        begin
            clock_ms += 1;
            send_report(good_report(prsc_pkg::MODE_B_CONTACT, 16'($urandom()), clock_ms));
        end
    endtask

    task automatic run_traffic(input int n_items);
        int          cap;
        int          sent;
        int          run_len;
        int          kind;
        int          roll;
        logic [31:0] delta;
        logic [7:0]  mode;
        logic [15:0] press;
        pen_report_t r;
        // Pick time steps that let a run reach the evidence window without
        // crossing the idle gap.
        cap = 2 * regs[prsc_pkg::CFG_EVIDENCE_MS]
            / ((regs[prsc_pkg::CFG_CONTACT_GOAL] == 0) ? 1
                                                       : regs[prsc_pkg::CFG_CONTACT_GOAL])
            + 1;
        if (regs[prsc_pkg::CFG_IDLE_RESET_MS] != 0
            && cap > regs[prsc_pkg::CFG_IDLE_RESET_MS] - 1)
            cap = regs[prsc_pkg::CFG_IDLE_RESET_MS] - 1;
        sent = 0;
        while (sent < n_items)
        begin
            idle_en = ($urandom_range(0, 4) != 0);
            kind    = $urandom_range(0, 9);
            run_len = $urandom_range(1, 40);
            for (int i = 0; i < run_len; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 92)
                    delta = $urandom_range(0, cap);
                else if (roll < 97)
                    delta = regs[prsc_pkg::CFG_IDLE_RESET_MS] + $urandom_range(0, 100);
                else
                    delta = $urandom();
                clock_ms += delta;
                press = 16'($urandom());
                if (kind <= 2)
                    mode = $urandom_range(0, 1) ? prsc_pkg::MODE_A_CONTACT
                                                : prsc_pkg::MODE_A_HOVER;
                else if (kind <= 6)
                begin
                    mode = ($urandom_range(0, 3) != 0) ? prsc_pkg::MODE_B_CONTACT
                                                       : prsc_pkg::MODE_B_HOVER;
                    if ($urandom_range(0, 1))
                        press = 16'($urandom_range(regs[prsc_pkg::CFG_SATURATION_LEVEL],
                                                   16'hFFFF));
                    else if (regs[prsc_pkg::CFG_SATURATION_LEVEL] != 0)
                        press = 16'($urandom_range(0,
                                    regs[prsc_pkg::CFG_SATURATION_LEVEL] - 1));
                end
                else
                    mode = 8'($urandom());
                r = good_report(mode, press, clock_ms);
                if (kind == 8)
                begin
                    r.vendor_id    = 16'($urandom());
                    r.product_id   = 16'($urandom());
                    r.usage_page   = 16'($urandom());
                    r.usage_code   = 16'($urandom());
                    r.name_matches = 1'($urandom());
                    r.parse_ok     = 1'($urandom());
                    r.report_id    = 8'($urandom());
                    r.now_ms       = $urandom();
                end
                else if (kind == 9)
                    r = break_filter(r, $urandom_range(0, 6));
                send_report(r);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        apply_reset_settings();
        run_traffic(190);
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
        run_traffic(190);
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF);
        run_traffic(190);
        apply_settings(16'($urandom()), 16'($urandom()), 16'd200, 16'd50, 16'd5, 16'd6,
                       16'd30000);
        run_traffic(190);
        apply_settings(16'($urandom()), 16'($urandom()), 16'($urandom_range(1, 65535)),
                       16'($urandom_range(0, 3000)), 16'($urandom_range(1, 30)),
                       16'($urandom_range(1, 30)), 16'($urandom()));
        run_traffic(190);
        apply_settings(prsc_pkg::VENDOR_RESET, prsc_pkg::PRODUCT_RESET,
                       prsc_pkg::IDLE_RESET_RESET, prsc_pkg::EVIDENCE_RESET,
                       16'd3, 16'd8, 16'd1);
        run_traffic(190);
    endtask

    // Result side: random stalls, and every result transfer is checked.
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(verdict_t)-1:0];
            if (pending_verdicts.size() == 0)
            begin
                if (mismatches < 10)
                    $display("cycle %0d: result with no report outstanding, tdata=%h",
                             cycles, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.accepted !== want.accepted || got.signature !== want.signature
                    || got.pressure_valid !== want.pressure_valid
                    || got.latest_pressure !== want.latest_pressure)
                begin
                    if (mismatches < 10)
                        $display({"cycle %0d: result mismatch, want acc=%0b sig=%0d ",
                                  "pv=%0b press=%0d, got acc=%0b sig=%0d pv=%0b press=%0d"},
                                 cycles, want.accepted, want.signature,
                                 want.pressure_valid, want.latest_pressure,
                                 got.accepted, got.signature, got.pressure_valid,
                                 got.latest_pressure);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_report_filters();
        test_pattern_verdicts();
        test_back_to_back_runs();
        test_random_traffic();
        drain();
        repeat (6) @(posedge clk);
        $display("checked %0d reports, %0d of them accepted, over ten register settings",
                 n_reports, n_accepted);
        $display("results held pattern A %0d times and pattern B %0d times; %0d mismatches",
                 n_sig_a, n_sig_b, mismatches);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("[pen_report_signature_classifier] OK");
        else
            $display("[pen_report_signature_classifier] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/prsc_pkg.sv
hw/rtl/pen_report_signature_classifier.sv
bench/tb.sv
